>>> hdl/tpam_pkg.sv
// Shared constants, codes and helper functions of the tensor permute address map.
package tpam_pkg;

  // Fixed geometry of the block.
  localparam int unsigned NDIM       = 4;
  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned DIM_BITS   = 12;
  localparam int unsigned SIZE_W     = DIM_BITS + 1;
  localparam int unsigned STR_W      = INDEX_BITS + 1;
  localparam int unsigned PROD_W     = STR_W + SIZE_W;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned PERM_W     = NDIM * SEL_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = SIZE_W;
  localparam int unsigned STATUS_W   = 2;

  // Element count limit and the largest legal dimension size.
  localparam logic [STR_W-1:0]  IndexLimit = STR_W'(1) << INDEX_BITS;
  localparam logic [SIZE_W-1:0] MaxSize    = SIZE_W'(1) << DIM_BITS;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT   = 3'd0,
    CFG_DIM_SIZE_0  = 3'd1,
    CFG_DIM_SIZE_1  = 3'd2,
    CFG_DIM_SIZE_2  = 3'd3,
    CFG_DIM_SIZE_3  = 3'd4,
    CFG_PERMUTATION = 3'd5
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RANGE  = 2'd1,
    STATUS_CONFIG = 2'd2
  } status_e;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]  DimCountReset = CNT_W'(NDIM);
  localparam logic [SIZE_W-1:0] DimSizeReset  = SIZE_W'(1);
  localparam logic [PERM_W-1:0] PermReset     = PERM_W'(228);

  // Clamp a product to one above the element limit so it fits a stride word.
  function automatic logic [STR_W-1:0] cap_product(input logic [PROD_W-1:0] p);
    logic [STR_W-1:0] r;
    if (p > PROD_W'(IndexLimit)) begin
      r = IndexLimit + STR_W'(1);
    end else begin
      r = p[STR_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/tensor_permute_address_map_core.sv
// Top level of the tensor permute address map: config decode, stride pipeline and datapath.
// done_o follows the delay line, the divider and the coordinate, permute and output stages.
// Throughput: one beat per cycle; busy_o stays low and a new index may enter every cycle.
// The 24-stage restoring divider splits the index into coordinates.
// Reset clears the valid bits and loads 4 dimensions of size 1 with the identity order.
// Results cannot be stalled: each one is on the outputs for exactly one cycle.
module tensor_permute_address_map_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tpam_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tpam_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [tpam_pkg::INDEX_BITS-1:0]      source_index_i,
  output logic                                 done_o,
  output logic [tpam_pkg::INDEX_BITS-1:0]      dest_position_o,
  output logic [tpam_pkg::INDEX_BITS-1:0]      source_echo_o,
  output logic [tpam_pkg::STATUS_W-1:0]        status_o
);

  localparam int unsigned NDIM   = tpam_pkg::NDIM;
  localparam int unsigned IDX_W  = tpam_pkg::INDEX_BITS;
  localparam int unsigned SIZE_W = tpam_pkg::SIZE_W;
  localparam int unsigned STR_W  = tpam_pkg::STR_W;
  localparam int unsigned PROD_W = tpam_pkg::PROD_W;
  localparam int unsigned SEL_W  = tpam_pkg::SEL_W;
  localparam int unsigned CNT_W  = tpam_pkg::CNT_W;
  localparam int unsigned DLY    = 4;
  localparam int unsigned DIV_ST = IDX_W;

  // Configuration registers.
  logic [CNT_W-1:0]           dim_count_q;
  logic [SIZE_W-1:0]          dim_size_q [NDIM];
  logic [tpam_pkg::PERM_W-1:0] perm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= tpam_pkg::DimCountReset;
      for (int k = 0; k < NDIM; k++) begin
        dim_size_q[k] <= tpam_pkg::DimSizeReset;
      end
      perm_q <= tpam_pkg::PermReset;
    end else if (cfg_we_i) begin
      case (tpam_pkg::cfg_idx_e'(cfg_idx_i))
        tpam_pkg::CFG_DIM_COUNT:   dim_count_q   <= cfg_wdata_i[CNT_W-1:0];
        tpam_pkg::CFG_DIM_SIZE_0:  dim_size_q[0] <= cfg_wdata_i;
        tpam_pkg::CFG_DIM_SIZE_1:  dim_size_q[1] <= cfg_wdata_i;
        tpam_pkg::CFG_DIM_SIZE_2:  dim_size_q[2] <= cfg_wdata_i;
        tpam_pkg::CFG_DIM_SIZE_3:  dim_size_q[3] <= cfg_wdata_i;
        tpam_pkg::CFG_PERMUTATION: perm_q        <= cfg_wdata_i[tpam_pkg::PERM_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode stage: effective sizes (unused dimensions act as size 1) and checks.
  logic [SIZE_W-1:0] eff_d [NDIM];
  logic [SIZE_W-1:0] osz_d [NDIM];
  logic [SEL_W-1:0]  sel_d [NDIM];
  logic              err_d;
  logic [SIZE_W-1:0] eff_q [NDIM];
  logic [SIZE_W-1:0] osz_q [NDIM];
  logic [SEL_W-1:0]  sel_q [NDIM];
  logic              dec_err_q;

  always_comb begin
    err_d = (dim_count_q == '0) || (dim_count_q > CNT_W'(NDIM));
    for (int k = 0; k < NDIM; k++) begin
      if (CNT_W'(k) < dim_count_q) begin
        eff_d[k] = dim_size_q[k];
        sel_d[k] = perm_q[SEL_W*k +: SEL_W];
        if ((dim_size_q[k] == '0) || (dim_size_q[k] > tpam_pkg::MaxSize)) begin
          err_d = 1'b1;
        end
        if (CNT_W'(sel_d[k]) >= dim_count_q) begin
          err_d = 1'b1;
        end
      end else begin
        eff_d[k] = SIZE_W'(1);
        sel_d[k] = SEL_W'(k);
      end
    end
    for (int k = 0; k < NDIM; k++) begin
      osz_d[k] = eff_d[sel_d[k]];
    end
  end

  // Stride stages: suffix products built one multiply per stage.
  logic [PROD_W-1:0] istr1_p, ostr1_p, istr0_p, ostr0_p, isize_p, osize_p;
  logic [STR_W-1:0]  istr2_q, ostr2_q, istr1_q, ostr1_q, istr0_q, ostr0_q;
  logic [STR_W-1:0]  isize_q, osize_q;
  logic              cfg_err_q;

  assign istr1_p = PROD_W'(eff_q[2]) * PROD_W'(eff_q[3]);
  assign ostr1_p = PROD_W'(osz_q[2]) * PROD_W'(osz_q[3]);
  assign istr0_p = PROD_W'(istr1_q) * PROD_W'(eff_q[1]);
  assign ostr0_p = PROD_W'(ostr1_q) * PROD_W'(osz_q[1]);
  assign isize_p = PROD_W'(istr0_q) * PROD_W'(eff_q[0]);
  assign osize_p = PROD_W'(ostr0_q) * PROD_W'(osz_q[0]);

  always_ff @(posedge clk_i) begin
    eff_q     <= eff_d;
    osz_q     <= osz_d;
    sel_q     <= sel_d;
    dec_err_q <= err_d;
    istr2_q   <= STR_W'(eff_q[3]);
    ostr2_q   <= STR_W'(osz_q[3]);
    istr1_q   <= tpam_pkg::cap_product(istr1_p);
    ostr1_q   <= tpam_pkg::cap_product(ostr1_p);
    istr0_q   <= tpam_pkg::cap_product(istr0_p);
    ostr0_q   <= tpam_pkg::cap_product(ostr0_p);
    isize_q   <= tpam_pkg::cap_product(isize_p);
    osize_q   <= tpam_pkg::cap_product(osize_p);
    cfg_err_q <= dec_err_q || (isize_q > tpam_pkg::IndexLimit) || (osize_q != isize_q);
  end

  logic [STR_W-1:0] istr [NDIM];
  logic [STR_W-1:0] ostr [NDIM];

  assign istr[0] = istr0_q;
  assign istr[1] = istr1_q;
  assign istr[2] = istr2_q;
  assign istr[3] = STR_W'(1);
  assign ostr[0] = ostr0_q;
  assign ostr[1] = ostr1_q;
  assign ostr[2] = ostr2_q;
  assign ostr[3] = STR_W'(1);

  // Input beat is taken every cycle; it then passes a delay line while the strides settle.
  assign busy_o = 1'b0;

  logic             dl_vld_q [DLY];
  logic [IDX_W-1:0] dl_src_q [DLY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DLY; s++) begin
        dl_vld_q[s] <= 1'b0;
      end
    end else begin
      dl_vld_q[0] <= start_i && !busy_o;
      for (int s = 1; s < DLY; s++) begin
        dl_vld_q[s] <= dl_vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_src_q[0] <= source_index_i;
    for (int s = 1; s < DLY; s++) begin
      dl_src_q[s] <= dl_src_q[s-1];
    end
  end

  // Restoring divider: one quotient bit per stage, one lane per input stride.
  logic             dv_vld_q [DIV_ST];
  logic [IDX_W-1:0] dv_src_q [DIV_ST];
  logic [STR_W-1:0] dv_rem_q [DIV_ST][NDIM];
  logic [IDX_W-1:0] dv_quo_q [DIV_ST][NDIM];
  logic [STR_W-1:0] dv_rem_d [DIV_ST][NDIM];
  logic [IDX_W-1:0] dv_quo_d [DIV_ST][NDIM];

  always_comb begin
    logic [STR_W-1:0] rem_in;
    logic [IDX_W-1:0] quo_in;
    logic [IDX_W-1:0] src_in;
    logic [STR_W:0]   shifted;
    logic             ge;
    for (int s = 0; s < DIV_ST; s++) begin
      for (int k = 0; k < NDIM; k++) begin
        if (s == 0) begin
          rem_in = '0;
          quo_in = '0;
          src_in = dl_src_q[DLY-1];
        end else begin
          rem_in = dv_rem_q[s-1][k];
          quo_in = dv_quo_q[s-1][k];
          src_in = dv_src_q[s-1];
        end
        shifted = {rem_in, src_in[IDX_W-1-s]};
        ge      = shifted >= {1'b0, istr[k]};
        if (ge) begin
          dv_rem_d[s][k] = STR_W'(shifted - {1'b0, istr[k]});
        end else begin
          dv_rem_d[s][k] = shifted[STR_W-1:0];
        end
        dv_quo_d[s][k] = {quo_in[IDX_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_ST; s++) begin
        dv_vld_q[s] <= 1'b0;
      end
    end else begin
      dv_vld_q[0] <= dl_vld_q[DLY-1];
      for (int s = 1; s < DIV_ST; s++) begin
        dv_vld_q[s] <= dv_vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_src_q[0] <= dl_src_q[DLY-1];
    for (int s = 1; s < DIV_ST; s++) begin
      dv_src_q[s] <= dv_src_q[s-1];
    end
    dv_rem_q <= dv_rem_d;
    dv_quo_q <= dv_quo_d;
  end

  // Coordinate stage: c[k] = q[k] - size[k] * q[k-1], exact in the low bits.
  logic              co_vld_q;
  logic [IDX_W-1:0]  co_src_q;
  logic [SIZE_W-1:0] coord_d [NDIM];
  logic [SIZE_W-1:0] coord_q [NDIM];

  always_comb begin
    coord_d[0] = dv_quo_q[DIV_ST-1][0][SIZE_W-1:0];
    for (int k = 1; k < NDIM; k++) begin
      coord_d[k] = dv_quo_q[DIV_ST-1][k][SIZE_W-1:0]
                 - SIZE_W'(eff_q[k] * dv_quo_q[DIV_ST-1][k-1][SIZE_W-1:0]);
    end
  end

  // Permute stage: each output dimension takes its source coordinate times its stride.
  logic              tm_vld_q;
  logic [IDX_W-1:0]  tm_src_q;
  logic [PROD_W-1:0] term_p [NDIM];
  logic [IDX_W-1:0]  term_q [NDIM];

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      term_p[d] = PROD_W'(coord_q[sel_q[d]]) * PROD_W'(ostr[d]);
    end
  end

  // Output stage: sum of terms and status.
  logic [IDX_W-1:0] pos_sum;
  logic             range_err;

  always_comb begin
    pos_sum = '0;
    for (int d = 0; d < NDIM; d++) begin
      pos_sum = pos_sum + term_q[d];
    end
  end

  assign range_err = {1'b0, tm_src_q} >= isize_q;

  logic                        done_q;
  logic [IDX_W-1:0]            dest_q;
  logic [IDX_W-1:0]            echo_q;
  tpam_pkg::status_e           status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co_vld_q <= 1'b0;
      tm_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      co_vld_q <= dv_vld_q[DIV_ST-1];
      tm_vld_q <= co_vld_q;
      done_q   <= tm_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    co_src_q <= dv_src_q[DIV_ST-1];
    coord_q  <= coord_d;
    tm_src_q <= co_src_q;
    for (int d = 0; d < NDIM; d++) begin
      term_q[d] <= term_p[d][IDX_W-1:0];
    end
    echo_q <= tm_src_q;
    if (cfg_err_q) begin
      status_q <= tpam_pkg::STATUS_CONFIG;
      dest_q   <= '0;
    end else if (range_err) begin
      status_q <= tpam_pkg::STATUS_RANGE;
      dest_q   <= '0;
    end else begin
      status_q <= tpam_pkg::STATUS_OK;
      dest_q   <= pos_sum;
    end
  end

  assign done_o          = done_q;
  assign dest_position_o = dest_q;
  assign source_echo_o   = echo_q;
  assign status_o        = status_q;

endmodule
